// File: hw/rtl/gic_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and output formatting helpers for the
// gamepad input conditioner. No dependencies.
package gic_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PER_AXIS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LX  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LY  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RX  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RY  = 3'd6;

	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 176;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} gic_state_t;

	// Per-cycle control from the sequencer to the serial axis unit.
	typedef struct packed {
		logic run;     // a step is taken this cycle
		logic first;   // first step of an axis: load operands
		logic pair_x;  // axis is the X of its stick: restart the radius sum
	} gic_step_ctl_t;

	// Status from the serial axis unit, meaningful on the last step.
	typedef struct packed {
		logic signed [9:0] value;     // axis value after dead zone
		logic              zero_pair; // radial test says zero the stick
	} gic_axis_res_t;

	// Stick byte: values above 127 show as 127.
	function automatic logic [7:0] stick_out(input logic signed [9:0] v);
		logic [7:0] r;
		if (v > 10'sd127) begin
			r = 8'h7F;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// Q1.15 normal (v * 256) pulled toward zero by off, saturated.
	function automatic logic [15:0] norm_out(input logic signed [9:0] v,
	                                         input logic [14:0] off);
		logic signed [18:0] n;
		logic signed [18:0] t;
		logic [15:0]        r;
		n = $signed({v[9], v, 8'b0});
		r = 16'h0000;
		if (n > 19'sd0) begin
			t = n - $signed({4'b0, off});
			if (t < 19'sd0) begin
				r = 16'h0000;
			end else if (t > 19'sd32767) begin
				r = 16'h7FFF;
			end else begin
				r = t[15:0];
			end
		end else if (n < 19'sd0) begin
			t = n + $signed({4'b0, off});
			if (t > 19'sd0) begin
				r = 16'h0000;
			end else begin
				r = t[15:0];
			end
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/gic_axis_serial.sv
`timescale 1ns / 1ps
// Serial dead-zone unit: one quotient bit of the rescale divide and one
// bit of the radius square per cycle. Uses gic_pkg.
module gic_axis_serial (
	input  logic                  clk,
	input  gic_pkg::gic_step_ctl_t ctl,
	input  logic signed [8:0]     v,
	input  logic [6:0]            dead_zone,
	input  logic                  per_axis_mode,
	output gic_pkg::gic_axis_res_t res
);
	import gic_pkg::*;

	logic [13:0] rem_q;
	logic [14:0] dvs_q;
	logic [7:0]  quo_q;
	logic [7:0]  mag_q;
	logic [13:0] add_q;
	logic [14:0] acc_q;
	logic [13:0] dz_sq_q;

	logic signed [9:0] v_w;
	logic signed [9:0] d_w;
	logic              pos;
	logic              neg;
	logic signed [9:0] m_pos;
	logic signed [9:0] m_neg;
	logic [7:0]        m;
	logic [14:0]       numer_w;
	logic [7:0]        k;
	logic [6:0]        mag_v;

	logic [13:0] rem_cur;
	logic [14:0] dvs_cur;
	logic [7:0]  quo_cur;
	logic [7:0]  mag_cur;
	logic [13:0] add_cur;
	logic [14:0] acc_cur;
	logic        ge;
	logic [7:0]  quo_next;
	logic [14:0] acc_next;
	logic signed [9:0] scaled;

	// Rescale numerator: (v + 1 - d) above the zone, -(v + d) below it.
	always_comb begin
		v_w     = {v[8], v};
		d_w     = $signed({3'b0, dead_zone});
		pos     = (v_w >= d_w);
		neg     = (v_w < -d_w);
		m_pos   = v_w + 10'sd1 - d_w;
		m_neg   = -v_w - d_w;
		m       = pos ? m_pos[7:0] : (neg ? m_neg[7:0] : 8'd0);
		numer_w = {m, 7'b0} - {7'b0, m};
		k       = 8'd128 - {1'b0, dead_zone};
		// clamp to 127 for the radial test
		if (v > 9'sd127 || v < -9'sd127) begin
			mag_v = 7'd127;
		end else if (v[8]) begin
			mag_v = 7'(-v);
		end else begin
			mag_v = v[6:0];
		end
	end

	// Operands enter through a mux on the first step of each axis.
	always_comb begin
		rem_cur  = ctl.first ? numer_w[13:0] : rem_q;
		dvs_cur  = ctl.first ? {k, 7'b0} : dvs_q;
		quo_cur  = ctl.first ? 8'd0 : quo_q;
		mag_cur  = ctl.first ? {1'b0, mag_v} : mag_q;
		add_cur  = ctl.first ? {mag_v, 7'b0} : add_q;
		acc_cur  = (ctl.first && ctl.pair_x) ? 15'd0 : acc_q;
		ge       = ({1'b0, rem_cur} >= dvs_cur);
		quo_next = {quo_cur[6:0], ge};
		acc_next = acc_cur + (mag_cur[7] ? {1'b0, add_cur} : 15'd0);
		scaled   = neg ? -$signed({2'b0, quo_next}) : $signed({2'b0, quo_next});
	end

	always_ff @(posedge clk) begin
		dz_sq_q <= 14'({7'b0, dead_zone} * {7'b0, dead_zone});
		if (ctl.run) begin
			rem_q <= ge ? (rem_cur - dvs_cur[13:0]) : rem_cur;
			dvs_q <= dvs_cur >> 1;
			quo_q <= quo_next;
			mag_q <= {mag_cur[6:0], 1'b0};
			add_q <= add_cur >> 1;
			acc_q <= acc_next;
		end
	end

	always_comb begin
		if (dead_zone == 7'd0 || !per_axis_mode) begin
			res.value = v_w;
		end else begin
			res.value = scaled;
		end
		res.zero_pair = (dead_zone != 7'd0) && !per_axis_mode &&
		                (acc_next < {1'b0, dz_sq_q});
	end

endmodule

// File: hw/rtl/gic_ramp_bank.sv
`timescale 1ns / 1ps
// Four Q16 d-pad hold ramps and their pressure levels.
// Has no dependencies; it does not import gic_pkg.
module gic_ramp_bank (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        update,
	input  logic [3:0]  held,       // left, right, up, down
	input  logic [16:0] ramp_step,
	output logic [31:0] levels      // left, right, up, down bytes from bit0
);
	localparam logic [16:0] RAMP_FULL = 17'd65536;
	localparam logic [16:0] LVL_LOW   = 17'd32768;
	localparam logic [16:0] LVL_MID   = 17'd49152;
	localparam logic [16:0] LVL_HIGH  = 17'd55705;

	logic [16:0] ramp_q [4];
	logic [16:0] ramp_new [4];
	logic [17:0] sum;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sum = {1'b0, ramp_q[i]} + {1'b0, ramp_step};
			if (!held[i]) begin
				ramp_new[i] = 17'd0;
			end else if (sum > {1'b0, RAMP_FULL}) begin
				ramp_new[i] = RAMP_FULL;
			end else begin
				ramp_new[i] = sum[16:0];
			end
			if (ramp_new[i] == 17'd0) begin
				levels[8*i +: 8] = 8'd0;
			end else if (ramp_new[i] <= LVL_LOW) begin
				levels[8*i +: 8] = 8'd25;
			end else if (ramp_new[i] <= LVL_MID) begin
				levels[8*i +: 8] = 8'd63;
			end else if (ramp_new[i] <= LVL_HIGH) begin
				levels[8*i +: 8] = 8'd127;
			end else begin
				levels[8*i +: 8] = 8'd255;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				ramp_q[i] <= 17'd0;
			end
		end else if (update) begin
			for (int i = 0; i < 4; i++) begin
				ramp_q[i] <= ramp_new[i];
			end
		end
	end

endmodule

// File: hw/rtl/gamepad_input_conditioner.sv
`timescale 1ns / 1ps
// Top level of the gamepad input conditioner: sequencer, config registers
// and output word register. Uses gic_pkg, gic_axis_serial, gic_ramp_bank.
//
// One controller scan goes in as a word and one conditioned word comes out.
// After acceptance a scan runs through the shared serial dead-zone unit
// (four axes, eight quotient bits each, one bit per cycle) and then forms
// the normals, pressures and button edges into the output register. A new
// scan is accepted only from the idle state, once the previous one has been
// loaded, so scans never overlap in the serial dead-zone unit.
// The serial divider loop bounds the scan rate. A finished word waits in the
// output register while the next scan is already taken and worked on; the
// block only holds off when a second result is ready before the first has
// been taken. Button edges and d-pad hold ramps advance when a result is
// loaded. Write config only while no scan is in flight.
module gamepad_input_conditioner (
	input  logic                                clk,
	input  logic                                arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [gic_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gic_pkg::CFG_DATA_W-1:0]      cfg_data,
	// scan input
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// raw_left_x, raw_left_y, raw_right_x, raw_right_y, buttons,
	// press_left, press_right, press_up, press_down, extra_a, extra_b
	input  logic [gic_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// pressure_flags
	input  logic [gic_pkg::IN_USER_W-1:0]       s_axis_tuser,
	// conditioned output
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// pressed_bits, released_bits, stick_left_x, stick_left_y,
	// stick_right_x, stick_right_y, norm_left_x, norm_left_y,
	// norm_right_x, norm_right_y, dpad_pressures, extra_pair
	output logic [gic_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
	import gic_pkg::*;

	gic_state_t state_q, state_next;
	logic [4:0] cnt_q;
	logic [1:0] axis;
	logic [2:0] step;
	logic       commit;

	// config registers
	logic [6:0]  dead_zone_q;
	logic        per_axis_q;
	logic [16:0] ramp_step_q;
	logic [14:0] offset_q [4];

	// captured scan
	logic [IN_DATA_W-1:0] in_data_q;
	logic [IN_USER_W-1:0] in_user_q;

	// axis values after dead zone
	logic signed [9:0] vals_q [4];

	logic [15:0] prev_btn_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_valid_q;

	logic [7:0]        raw;
	logic signed [8:0] v;
	gic_step_ctl_t     ctl;
	gic_axis_res_t     res;
	logic [3:0]        held;
	logic [31:0]       levels;
	logic [15:0]       btn;
	logic [31:0]       dpad;
	logic [15:0]       extra;

	assign axis = cnt_q[4:3];
	assign step = cnt_q[2:0];
	assign btn  = in_data_q[47:32];

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (cnt_q == 5'd31) begin
					state_next = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		commit        = 1'b0;
		ctl.run       = 1'b0;
		case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_RUN:  ctl.run = 1'b1;
			ST_DONE: commit = !out_valid_q || m_axis_tready;
			default: ;
		endcase
		ctl.first  = (step == 3'd0);
		ctl.pair_x = ~axis[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= 5'd0;
		end else begin
			state_q <= state_next;
			if (ctl.run) begin
				cnt_q <= cnt_q + 5'd1;
			end else begin
				cnt_q <= 5'd0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Config registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_zone_q <= 7'd0;
			per_axis_q  <= 1'b0;
			ramp_step_q <= 17'd218;
			for (int i = 0; i < 4; i++) begin
				offset_q[i] <= 15'd0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEAD_ZONE: dead_zone_q <= cfg_data[6:0];
				CFG_PER_AXIS:  per_axis_q  <= cfg_data[0];
				CFG_RAMP_STEP: ramp_step_q <= cfg_data[16:0];
				CFG_OFFSET_LX: offset_q[0] <= cfg_data[14:0];
				CFG_OFFSET_LY: offset_q[1] <= cfg_data[14:0];
				CFG_OFFSET_RX: offset_q[2] <= cfg_data[14:0];
				CFG_OFFSET_RY: offset_q[3] <= cfg_data[14:0];
				default: ;   // drop writes beyond the register list
			endcase
		end
	end

	// Capture the scan word on acceptance.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			in_data_q <= s_axis_tdata;
			in_user_q <= s_axis_tuser;
		end
	end

	// ---------------------------------------------------------------
	// Axis feed: centre by 128, Y flipped so that up is positive
	// ---------------------------------------------------------------
	always_comb begin
		raw = in_data_q[8*axis +: 8];
		if (axis[0]) begin
			v = 9'sd128 - $signed({1'b0, raw});
		end else begin
			v = $signed({~raw[7], ~raw[7], raw[6:0]});
		end
	end

	gic_axis_serial u_axis (
		.clk           (clk),
		.ctl           (ctl),
		.v             (v),
		.dead_zone     (dead_zone_q),
		.per_axis_mode (per_axis_q),
		.res           (res)
	);

	// Store each axis on its last step; the radial test zeroes the whole
	// stick once the Y square has been added in.
	always_ff @(posedge clk) begin
		if (ctl.run && step == 3'd7) begin
			for (int i = 0; i < 4; i++) begin
				if (axis == 2'(i)) begin
					vals_q[i] <= (axis[0] && res.zero_pair) ? 10'sd0 : res.value;
				end else if (axis[0] && res.zero_pair && (axis - 2'd1) == 2'(i)) begin
					vals_q[i] <= 10'sd0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// D-pad ramps: advance only when no pressures are supplied
	// ---------------------------------------------------------------
	assign held = {btn[14], btn[12], btn[13], btn[15]};

	gic_ramp_bank u_ramp (
		.clk       (clk),
		.arst_n    (arst_n),
		.update    (commit && !in_user_q[0]),
		.held      (held),
		.ramp_step (ramp_step_q),
		.levels    (levels)
	);

	assign dpad  = in_user_q[0] ? in_data_q[79:48] : levels;
	assign extra = in_user_q[1] ? in_data_q[95:80] : 16'h7F7F;

	// ---------------------------------------------------------------
	// Output word register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prev_btn_q  <= 16'h0000;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
				prev_btn_q  <= btn;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q[15:0]    <= btn & ~prev_btn_q;
			out_data_q[31:16]   <= ~btn & prev_btn_q;
			out_data_q[39:32]   <= stick_out(vals_q[0]);
			out_data_q[47:40]   <= stick_out(vals_q[1]);
			out_data_q[55:48]   <= stick_out(vals_q[2]);
			out_data_q[63:56]   <= stick_out(vals_q[3]);
			out_data_q[79:64]   <= norm_out(vals_q[0], offset_q[0]);
			out_data_q[95:80]   <= norm_out(vals_q[1], offset_q[1]);
			out_data_q[111:96]  <= norm_out(vals_q[2], offset_q[2]);
			out_data_q[127:112] <= norm_out(vals_q[3], offset_q[3]);
			out_data_q[159:128] <= dpad;
			out_data_q[175:160] <= extra;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("output word appeared without a finished scan");

	a_accept_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (state_q == ST_RUN && cnt_q == 5'd0))
		else $error("accepted scan did not start the serial run at step zero");

	a_run_length: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && cnt_q == 5'd31) |=> (state_q == ST_DONE))
		else $error("serial run did not end after four axes");

	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ((m_axis_tdata[15:0] & m_axis_tdata[31:16]) == 16'h0000))
		else $error("a button reported both pressed and released");
`endif

endmodule

// File: dv/gamepad_input_conditioner_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gamepad_input_conditioner: streams controller scans,
// predicts each conditioned word and compares it field by field.
// Depends on gic_pkg and the block's RTL only.
module gamepad_input_conditioner_tb;
	import gic_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_STALL     = 400;
	localparam int PHASE_ITEMS    = 105;
	localparam int NUM_FIELDS     = 12;
	localparam int REPORT_LIMIT   = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	// Bit position and width of each field of the conditioned word, lowest first.
	localparam int FIELD_LSB[NUM_FIELDS] = '{0, 16, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160};
	localparam int FIELD_W[NUM_FIELDS]   = '{16, 16, 8, 8, 8, 8, 16, 16, 16, 16, 32, 16};

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	// Predicts conditioned words from accepted scans and checks the block's output.
	class cond_scoreboard;
		int unsigned dead_zone;
		int unsigned per_axis;
		int unsigned ramp_step;
		int unsigned pull[4];
		logic [15:0] last_buttons;
		int unsigned ramp[4];
		logic [OUT_DATA_W-1:0] cond_words_q[$];
		int mismatches;
		string field_name[NUM_FIELDS];

		function new();
			field_name = '{"pressed_bits", "released_bits", "stick_left_x", "stick_left_y",
				"stick_right_x", "stick_right_y", "norm_left_x", "norm_left_y",
				"norm_right_x", "norm_right_y", "dpad_pressures", "extra_pair"};
			dead_zone = 0;
			per_axis = 0;
			ramp_step = 218;
			last_buttons = '0;
			mismatches = 0;
			for (int i = 0; i < 4; i++) begin
				pull[i] = 0;
				ramp[i] = 0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_DEAD_ZONE: dead_zone = 32'(val[6:0]);
				CFG_PER_AXIS:  per_axis  = 32'(val[0]);
				CFG_RAMP_STEP: ramp_step = 32'(val[16:0]);
				CFG_OFFSET_LX: pull[0]   = 32'(val[14:0]);
				CFG_OFFSET_LY: pull[1]   = 32'(val[14:0]);
				CFG_OFFSET_RX: pull[2]   = 32'(val[14:0]);
				CFG_OFFSET_RY: pull[3]   = 32'(val[14:0]);
				default: ;
			endcase
		endfunction

		function int rescale_axis(int v, int d);
			int k;
			k = 128 - d;
			if (v >= d)
				return ((v + 1 - d) * 127) / k;
			if (v < -d)
				return ((v + d) * 127) / k;
			return 0;
		endfunction

		function int clip127(int v);
			if (v > 127) return 127;
			if (v < -127) return -127;
			return v;
		endfunction

		function void shape_stick(inout int x, inout int y);
			int d;
			int cx;
			int cy;
			d = int'(dead_zone);
			if (per_axis != 0) begin
				x = rescale_axis(x, d);
				y = rescale_axis(y, d);
			end else begin
				cx = clip127(x);
				cy = clip127(y);
				if (cx * cx + cy * cy < d * d) begin
					x = 0;
					y = 0;
				end
			end
		endfunction

		function logic [7:0] stick_byte(int v);
			logic [31:0] t;
			if (v > 127) v = 127;
			if (v < -128) v = -128;
			t = v;
			return t[7:0];
		endfunction

		function logic [15:0] normal(int v, int unsigned off);
			int n;
			logic [31:0] t;
			n = v * 256;
			if (n > 0) begin
				n = n - int'(off);
				if (n < 0) n = 0;
			end else if (n < 0) begin
				n = n + int'(off);
				if (n > 0) n = 0;
			end
			if (n > 32767) n = 32767;
			if (n < -32768) n = -32768;
			t = n;
			return t[15:0];
		endfunction

		function logic [7:0] ramp_level(int unsigned r);
			if (r == 0) return 8'd0;
			if (r <= 32768) return 8'd25;
			if (r <= 49152) return 8'd63;
			if (r <= 55705) return 8'd127;
			return 8'd255;
		endfunction

		// Work out the conditioned word for one scan and advance edge and ramp state.
		function logic [OUT_DATA_W-1:0] condition_scan(logic [IN_DATA_W-1:0] d,
		                                               logic [IN_USER_W-1:0] flags);
			logic [15:0] btn;
			logic [15:0] pressed;
			logic [15:0] released;
			logic [31:0] dpad;
			logic [15:0] extra;
			int lx;
			int ly;
			int rx;
			int ry;
			int unsigned s;
			int dir_bit[4];
			dir_bit = '{15, 13, 12, 14};
			btn = d[47:32];
			pressed = btn & ~last_buttons;
			released = ~btn & last_buttons;
			last_buttons = btn;
			lx = int'(d[7:0]) - 128;
			ly = 128 - int'(d[15:8]);
			rx = int'(d[23:16]) - 128;
			ry = 128 - int'(d[31:24]);
			if (dead_zone != 0) begin
				shape_stick(lx, ly);
				shape_stick(rx, ry);
			end
			if (flags[0]) begin
				dpad = d[79:48];
			end else begin
				dpad = '0;
				for (int i = 0; i < 4; i++) begin
					if (btn[dir_bit[i]]) begin
						s = ramp[i] + ramp_step;
						ramp[i] = (s > 65536) ? 65536 : s;
					end else begin
						ramp[i] = 0;
					end
					dpad = dpad | (32'(ramp_level(ramp[i])) << (8 * i));
				end
			end
			extra = flags[1] ? d[95:80] : 16'h7F7F;
			return {extra, dpad, normal(ry, pull[3]), normal(rx, pull[2]),
				normal(ly, pull[1]), normal(lx, pull[0]), stick_byte(ry), stick_byte(rx),
				stick_byte(ly), stick_byte(lx), released, pressed};
		endfunction

		function void note_scan(logic [IN_DATA_W-1:0] d, logic [IN_USER_W-1:0] flags);
			cond_words_q.push_back(condition_scan(d, flags));
		endfunction

		function void check_word(logic [OUT_DATA_W-1:0] got);
			logic [OUT_DATA_W-1:0] want;
			logic [OUT_DATA_W-1:0] ws;
			logic [OUT_DATA_W-1:0] gs;
			logic [63:0] mask;
			if (cond_words_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: word with no scan pending: %h", $realtime, got);
				return;
			end
			want = cond_words_q.pop_front();
			for (int f = 0; f < NUM_FIELDS; f++) begin
				mask = (64'd1 << FIELD_W[f]) - 64'd1;
				ws = want >> FIELD_LSB[f];
				gs = got >> FIELD_LSB[f];
				if ((ws[31:0] & mask[31:0]) != (gs[31:0] & mask[31:0])) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: %s expected %h, actual %h", $realtime, field_name[f],
							ws[31:0] & mask[31:0], gs[31:0] & mask[31:0]);
				end
			end
		endfunction

		function int pending();
			return cond_words_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// raw_left_x, raw_left_y, raw_right_x, raw_right_y, buttons, press_left,
	// press_right, press_up, press_down, extra_a, extra_b
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
	// pressure_flags
	logic [IN_USER_W-1:0]   s_axis_tuser = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// pressed_bits, released_bits, stick_left_x, stick_left_y, stick_right_x,
	// stick_right_y, norm_left_x, norm_left_y, norm_right_x, norm_right_y,
	// dpad_pressures, extra_pair
	logic [OUT_DATA_W-1:0]  m_axis_tdata;

	cond_scoreboard sb = new();

	int       burst_left = 0;
	logic [3:0] dpad_held = '0;
	bit       long_stall_req = 1'b0;
	int       quiet;

	gamepad_input_conditioner u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	// Check every word taken from the output. Values read right after the edge
	// are the ones the block saw at that edge.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata);
	end

	// Receiver: switch among always-ready, random and periodic patterns, and
	// hold off for a long stretch when asked so the block backs up its input.
	initial begin
		rx_mode_t rx_mode;
		int mode_left;
		int stall_left;
		int phase_cnt;
		bit ready_next;
		rx_mode = RX_ALWAYS;
		mode_left = 0;
		stall_left = 0;
		phase_cnt = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0) begin
				stall_left--;
				ready_next = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				phase_cnt++;
				case (rx_mode)
					RX_ALWAYS:   ready_next = 1'b1;
					RX_RANDOM:   ready_next = ($urandom_range(0, 99) < 60);
					default:     ready_next = (phase_cnt % 5 == 0);
				endcase
			end
			m_axis_tready <= ready_next;
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	initial begin
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	// Offer one scan and hold it until taken. Scans go out in bursts; between
	// bursts drop valid for a random gap. Note the scan on the accepting edge.
	task automatic drive_scan(input logic [IN_DATA_W-1:0] d, input logic [IN_USER_W-1:0] u);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 30);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= u;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_scan(d, u);
		burst_left--;
	endtask

	// Stop offering and wait until every predicted word has come out.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Drive the write port through a clock edge; the caller lowers the enable.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] dz, input logic [CFG_DATA_W-1:0] mode,
	                             input logic [CFG_DATA_W-1:0] step, input logic [CFG_DATA_W-1:0] olx,
	                             input logic [CFG_DATA_W-1:0] oly, input logic [CFG_DATA_W-1:0] orx,
	                             input logic [CFG_DATA_W-1:0] ory);
		write_reg(CFG_DEAD_ZONE, dz);
		write_reg(CFG_PER_AXIS, mode);
		write_reg(CFG_RAMP_STEP, step);
		write_reg(CFG_OFFSET_LX, olx);
		write_reg(CFG_OFFSET_LY, oly);
		write_reg(CFG_OFFSET_RX, orx);
		write_reg(CFG_OFFSET_RY, ory);
		cfg_we <= 1'b0;
	endtask

	// Stick byte: extremes, values around the dead zone edge, or anything.
	function automatic logic [7:0] pick_axis(int unsigned dz);
		logic [7:0] edge_vals[7];
		int c;
		edge_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
		case ($urandom_range(0, 3))
			0: return edge_vals[$urandom_range(0, 6)];
			1: begin
				c = 128 - (int'(dz) + 2) + int'($urandom_range(0, 2 * dz + 4));
				if (c < 0) c = 0;
				if (c > 255) c = 255;
				return c[7:0];
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly held d-pad directions so the ramps climb through their levels;
	// now and then scramble them, and sometimes supply pressures directly.
	task automatic random_scan(output logic [IN_DATA_W-1:0] d, output logic [IN_USER_W-1:0] u);
		logic [11:0] low_btn;
		logic [7:0] pb[6];
		if ($urandom_range(0, 19) == 0) begin
			dpad_held = 4'($urandom_range(0, 15));
		end else begin
			for (int i = 0; i < 4; i++)
				if ($urandom_range(0, 15) == 0) dpad_held[i] = ~dpad_held[i];
		end
		low_btn = 12'($urandom_range(0, 4095));
		for (int i = 0; i < 6; i++)
			pb[i] = 8'($urandom_range(0, 255));
		u[0] = ($urandom_range(0, 3) == 0);
		u[1] = 1'($urandom_range(0, 1));
		d = {pb[5], pb[4], pb[3], pb[2], pb[1], pb[0], dpad_held, low_btn,
			pick_axis(sb.dead_zone), pick_axis(sb.dead_zone),
			pick_axis(sb.dead_zone), pick_axis(sb.dead_zone)};
	endtask

	task automatic run_random(input int n);
		logic [IN_DATA_W-1:0] d;
		logic [IN_USER_W-1:0] u;
		repeat (n) begin
			random_scan(d, u);
			drive_scan(d, u);
		end
	endtask

	initial begin
		logic [7:0] axis_tbl[8];
		logic [15:0] btn_tbl[8];
		logic [7:0] pv;
		logic [IN_DATA_W-1:0] d;
		axis_tbl = '{8'd0, 8'd255, 8'd128, 8'd127, 8'd129, 8'd1, 8'd254, 8'd64};
		btn_tbl = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A,
			16'hF000, 16'h0FFF};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed scans at reset settings: stick extremes and centre, full and
		// empty button sets with both edges, every pressure flag combination.
		for (int i = 0; i < 16; i++) begin
			pv = i[0] ? 8'hFF : 8'h00;
			d = {pv, ~pv, ~pv, pv, pv, ~pv, btn_tbl[i % 8], axis_tbl[(i + 3) % 8],
				axis_tbl[(i + 2) % 8], axis_tbl[(i + 1) % 8], axis_tbl[i % 8]};
			drive_scan(d, 2'(i % 4));
		end
		drain();

		// Widest radial zone, instant full ramps, largest pulls toward zero.
		apply_setting(17'd127, 17'd0, 17'd65536, 17'd32767, 17'd32767, 17'd32767, 17'd32767);
		run_random(PHASE_ITEMS);
		drain();

		// Widest per-axis zone (unit divisor), frozen ramps; back up the output.
		apply_setting(17'd127, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
		long_stall_req = 1'b1;
		run_random(PHASE_ITEMS);
		drain();

		// Narrowest per-axis zone; ramp steps that land on level boundaries.
		apply_setting(17'd1, 17'd1, 17'd8192, 17'($urandom_range(0, 32767)),
			17'($urandom_range(0, 32767)), 17'($urandom_range(0, 32767)),
			17'($urandom_range(0, 32767)));
		run_random(PHASE_ITEMS);
		drain();

		// Random radial zone; one step lands exactly on the top boundary level.
		apply_setting(17'($urandom_range(1, 126)), 17'd0, 17'd55705,
			17'($urandom_range(0, 32767)), 17'($urandom_range(0, 32767)),
			17'($urandom_range(0, 32767)), 17'($urandom_range(0, 32767)));
		run_random(PHASE_ITEMS);
		drain();

		// Unused index must be ignored; high data bits are masked off, which
		// leaves the dead zone disabled and per-axis mode set.
		write_reg(CFG_UNUSED_IDX, 17'($urandom_range(0, 131071)));
		apply_setting(17'h1FF80, 17'h1FFFF, 17'($urandom_range(1, 20000)),
			17'($urandom_range(0, 32767)), 17'($urandom_range(0, 32767)),
			17'($urandom_range(0, 32767)), 17'($urandom_range(0, 32767)));
		run_random(PHASE_ITEMS);
		drain();

		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
